// File: sv/double_ended_queue_defines.svh
// Assertion macros shared by the deque RTL.
// Users must have clk_i and rst_ni in scope; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define DQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; used by the channel interfaces and all RTL modules.
package dq_pkg;

  localparam int unsigned DQ_DEPTH = 16;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned OCC_W    = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

endpackage

// File: sv/dq_if.sv
// Valid/ready channel interfaces for the command and response words.
// Depends on dq_pkg for field widths.
interface dq_cmd_if;
  import dq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [VAL_W-1:0]  push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface dq_rsp_if;
  import dq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  pop_value;
  logic [ST_W-1:0]          status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  output ready);
endinterface

// File: sv/dq_ram.sv
// Single-port-write, single-port-read ring storage with a registered read.
// Depends on dq_pkg for the value width.
module dq_ram #(
  parameter int unsigned DEPTH = dq_pkg::DQ_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [dq_pkg::VAL_W-1:0]      wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [dq_pkg::VAL_W-1:0]      rdata_o
);
  import dq_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit values.
// Depends on dq_pkg, the dq_cmd_if/dq_rsp_if interfaces, dq_ram and the defines header.
//
//   Channel | Port  | Direction | Word carries
//   --------+-------+-----------+-------------------------------------
//   command | cmd_i | in        | cmd, push_value
//   result  | rsp_o | out       | pop_value, status, occupancy
//
// A push, or a pop on an empty queue, loads its result word into the output
// register at the edge that accepts the command.
// A successful pop first reads the ring memory into its read register and then
// loads the output register from it; no command is accepted during its read cycle.
// Reset clears the front index, the element count and the control state, not the memory.
// A command is accepted while idle and the result register is empty or being drained.
`include "double_ended_queue_defines.svh"

module double_ended_queue #(
  parameter int unsigned DEPTH = dq_pkg::DQ_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dq_cmd_if.sink    cmd_i,
  dq_rsp_if.source  rsp_o
);
  import dq_pkg::*;

  // Index width and count width; the count must be able to hold DEPTH itself.
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_X  = (CW + 1)'(DEPTH);

  state_e              state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;

  logic                out_valid_q, out_valid_d;
  logic [VAL_W-1:0]    out_value_q, out_value_d;
  status_e             out_status_q, out_status_d;
  logic [OCC_W-1:0]    out_occ_q, out_occ_d;

  // Memory port signals.
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [VAL_W-1:0]    mem_rdata;

  cmd_e                cmd;
  logic                is_push;
  logic                full;
  logic                empty;
  logic                cmd_acc;
  logic [AW-1:0]       head_dec;
  logic [AW-1:0]       head_inc;
  logic [CW:0]         sum_back;
  logic [CW:0]         sum_last;
  logic [AW-1:0]       back_slot;
  logic [AW-1:0]       last_slot;

  assign cmd     = cmd_e'(cmd_i.cmd);
  assign is_push = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK);
  assign full    = (count_q == FULL_CNT);
  assign empty   = (count_q == '0);

  // Only one command is in flight, and a pop reads after any earlier push
  // has been written, so the memory never sees a read and write collide.
  assign cmd_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  // Ring index arithmetic. The sums stay below twice DEPTH, so one
  // compare and subtract wraps them for any DEPTH, not only powers of two.
  assign head_dec  = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
  assign head_inc  = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
  assign sum_back  = (CW + 1)'(head_q) + (CW + 1)'(count_q);
  assign sum_last  = sum_back - 1'b1;
  assign back_slot = (sum_back >= DEPTH_X) ? AW'(sum_back - DEPTH_X) : AW'(sum_back);
  assign last_slot = (sum_last >= DEPTH_X) ? AW'(sum_last - DEPTH_X) : AW'(sum_last);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    mem_we       = 1'b0;
    mem_waddr    = back_slot;
    mem_re       = 1'b0;
    mem_raddr    = head_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_acc) begin
          out_value_d  = '0;
          out_status_d = ST_OK;
          if (is_push) begin
            if (full) begin
              out_status_d = ST_FULL;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + 1'b1;
              if (cmd == CMD_PUSH_FRONT) begin
                head_d    = head_dec;
                mem_waddr = head_dec;
              end else begin
                mem_waddr = back_slot;
              end
            end
            out_valid_d = 1'b1;
          end else begin
            if (empty) begin
              out_status_d = ST_EMPTY;
              out_valid_d  = 1'b1;
            end else begin
              // The read data returns next cycle, in the read state, and is then registered into the result word.
              mem_re  = 1'b1;
              count_d = count_q - 1'b1;
              state_d = S_READ;
              if (cmd == CMD_POP_FRONT) begin
                mem_raddr = head_q;
                head_d    = head_inc;
              end else begin
                mem_raddr = last_slot;
              end
            end
          end
          out_occ_d = OCC_W'(count_d);
        end
      end
      S_READ: begin
        // The result register was free when the pop was accepted.
        out_valid_d = 1'b1;
        out_value_d = mem_rdata;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

  dq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (cmd_i.push_value),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.pop_value = out_value_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.occupancy = out_occ_q;

  // The element count never passes the ring size, and the front index
  // always names a real entry.
  `DQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= FULL_CNT, "count exceeds depth")
  `DQ_ASSERT_IMP(a_head_bound, 1'b1, head_q <= LAST_IDX, "front index out of range")
  // A push that fits grows the queue by exactly one.
  `DQ_ASSERT_NXT(a_push_grows, cmd_acc && is_push && !full,
                 count_q == $past(count_q) + 1'b1, "push did not grow queue")
  // A pop on a live queue is followed by the read state for the memory, with no result shown.
  `DQ_ASSERT_NXT(a_pop_reads, cmd_acc && !is_push && !empty,
                 state_q == S_READ && !out_valid_q, "pop skipped memory read")
  // The read cycle always ends with a result word in the output register.
  `DQ_ASSERT_NXT(a_read_done, state_q == S_READ,
                 out_valid_q && state_q == S_IDLE, "pop result not loaded")

endmodule
